>>> rtl/core/glyph_quad_vertex_generator_top_assert.svh
// assertion helpers for the core modules, included by gqvg_back
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define GQVG_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GQVG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define GQVG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/gqvg_pkg.sv
package gqvg_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_DRAW  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_SPACE = 2'd1,
      KIND_DRAW  = 2'd2
   } kind_type;

   localparam logic [1:0] CSR_LINE_HEIGHT   = 2'd0;
   localparam logic [1:0] CSR_SPACE_ADVANCE = 2'd1;
   localparam logic [1:0] CSR_GLYPH_GAP     = 2'd2;

   localparam logic [7:0] SPACE_CODE = 8'd32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [16:0] left;
      logic [16:0] right;
      logic [7:0]  width;
   } glyph_type;

   typedef struct packed {
      logic [11:0] line_height;
      logic [7:0]  space_advance;
      logic [7:0]  glyph_gap;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] x;
      logic [15:0] y;
      glyph_type   glyph;
   } entry_type;

endpackage

>>> rtl/core/glyph_quad_vertex_generator_top.sv
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    operation, char_code, glyph_*, start_x/y
// rsp       out  rsp_valid/rsp_ready    vertex_index, pos_x/y, tex_u/v, last
// csr       in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// the front takes one req beat per cycle while req_ready is high; table writes
// finish there. start and space are consumed in the back with no vertex; a drawn
// glyph gives four, one vertex per rsp beat from the output register
// req beats pass the front register, a four-entry queue and the output register;
// the queue lets the front keep taking beats while the back waits on rsp_ready
// reset clears the glyph valid bits at once, so no clearing pass is needed
module glyph_quad_vertex_generator_top #(
   parameter int GLYPH_COUNT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_char_code,
   input  logic [16:0]        req_glyph_left,
   input  logic [16:0]        req_glyph_right,
   input  logic [7:0]         req_glyph_width,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_vertex_index,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [16:0]        rsp_tex_u,
   output logic               rsp_tex_v,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_data
);
   import gqvg_pkg::*;

   cfg_type     cfg_ff;
   logic        csr_write;
   logic        push_valid;
   logic        push_ready;
   entry_type   push_entry;
   logic        head_valid;
   entry_type   head_entry;
   logic        pop;
   logic [15:0] pos_x;
   logic [15:0] pos_y;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_height   <= 12'd0;
         cfg_ff.space_advance <= 8'd3;
         cfg_ff.glyph_gap     <= 8'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LINE_HEIGHT:   cfg_ff.line_height   <= csr_data;
            CSR_SPACE_ADVANCE: cfg_ff.space_advance <= csr_data[7:0];
            CSR_GLYPH_GAP:     cfg_ff.glyph_gap     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   gqvg_front #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_char_code   (req_char_code),
      .req_glyph_left  (req_glyph_left),
      .req_glyph_right (req_glyph_right),
      .req_glyph_width (req_glyph_width),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   gqvg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   gqvg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_pos_x        (pos_x),
      .rsp_pos_y        (pos_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_last         (rsp_last)
   );

   assign rsp_pos_x = pos_x;
   assign rsp_pos_y = pos_y;
endmodule

>>> rtl/core/gqvg_ram.sv
module gqvg_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/gqvg_front.sv
module gqvg_front #(
   parameter int GLYPH_COUNT = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_char_code,
   input  logic [16:0]         req_glyph_left,
   input  logic [16:0]         req_glyph_right,
   input  logic [7:0]          req_glyph_width,
   input  logic signed [15:0]  req_start_x,
   input  logic signed [15:0]  req_start_y,
   output logic                push_valid,
   input  logic                push_ready,
   output gqvg_pkg::entry_type push_entry
);
   import gqvg_pkg::*;

   localparam int AW = $clog2(GLYPH_COUNT);
   localparam logic [8:0] GCOUNT = 9'(GLYPH_COUNT);

   logic                   accept;
   logic [7:0]             sym;
   logic                   wr_en;
   logic                   rd_en;
   logic                   keep;
   kind_type               kind;
   logic [GLYPH_COUNT-1:0] valid_ff;
   logic [GLYPH_COUNT-1:0] valid_in;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   kind_type               s1_kind_ff;
   logic [15:0]            s1_x_ff;
   logic [15:0]            s1_y_ff;
   logic                   s1_hit_ff;
   glyph_type              wr_glyph;
   glyph_type              rd_glyph;

   assign accept = req_valid && req_ready;
   assign sym    = req_char_code - SPACE_CODE;

   // classify the beat; dropped codes never reach the queue
   always_comb begin
      wr_en = 1'b0;
      rd_en = 1'b0;
      keep  = 1'b0;
      kind  = KIND_START;
      case (op_type'(req_operation))
         OP_WRITE: begin
            wr_en = accept && ({1'b0, req_char_code} < GCOUNT);
         end
         OP_START: begin
            keep = accept;
            kind = KIND_START;
         end
         OP_DRAW: begin
            if (req_char_code >= SPACE_CODE) begin
               if (sym == 8'd0) begin
                  keep = accept;
                  kind = KIND_SPACE;
               end else if ({1'b0, sym} < GCOUNT) begin
                  keep  = accept;
                  rd_en = accept;
                  kind  = KIND_DRAW;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[req_char_code[AW-1:0]] = 1'b1;
      end
   end

   assign wr_glyph.left  = req_glyph_left;
   assign wr_glyph.right = req_glyph_right;
   assign wr_glyph.width = req_glyph_width;

   gqvg_ram #(
      .WIDTH ($bits(glyph_type)),
      .DEPTH (GLYPH_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_char_code[AW-1:0]),
      .wr_data (wr_glyph),
      .rd_en   (rd_en),
      .rd_addr (sym[AW-1:0]),
      .rd_data (rd_glyph)
   );

   assign s1_valid_in = keep || (s1_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         s1_kind_ff <= kind;
         s1_x_ff    <= req_start_x;
         s1_y_ff    <= req_start_y;
         s1_hit_ff  <= valid_ff[sym[AW-1:0]];
      end
   end

   assign req_ready  = !s1_valid_ff || push_ready;
   assign push_valid = s1_valid_ff;

   // entries never written read as zero
   always_comb begin
      push_entry.kind  = s1_kind_ff;
      push_entry.x     = s1_x_ff;
      push_entry.y     = s1_y_ff;
      push_entry.glyph = s1_hit_ff ? rd_glyph : '0;
   end
endmodule

>>> rtl/core/gqvg_queue.sv
module gqvg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  gqvg_pkg::entry_type push_entry,
   output logic                head_valid,
   input  logic                pop,
   output gqvg_pkg::entry_type head_entry
);
   import gqvg_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               push;
   logic               take;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign take       = pop && head_valid;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

>>> rtl/core/gqvg_back.sv
module gqvg_back (
   input  logic                clock,
   input  logic                reset,
   input  gqvg_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  gqvg_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_vertex_index,
   output logic [15:0]         rsp_pos_x,
   output logic [15:0]         rsp_pos_y,
   output logic [16:0]         rsp_tex_u,
   output logic                rsp_tex_v,
   output logic                rsp_last
);
   import gqvg_pkg::*;

   `include "glyph_quad_vertex_generator_top_assert.svh"

   logic [15:0] pen_x_ff;
   logic [15:0] pen_x_in;
   logic [15:0] pen_y_ff;
   logic [15:0] pen_y_in;
   logic [15:0] vcount_ff;
   logic [15:0] vcount_in;
   logic [1:0]  k_ff;
   logic [1:0]  k_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] index_ff;
   logic [15:0] pos_x_ff;
   logic [15:0] pos_y_ff;
   logic [16:0] tex_u_ff;
   logic        tex_v_ff;
   logic        last_ff;
   logic        out_free;
   logic        load;
   logic [15:0] x1;
   logic [15:0] y1;
   logic        right_side;
   logic        bottom;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign x1         = pen_x_ff + {8'd0, head_entry.glyph.width};
   assign y1         = pen_y_ff - {4'd0, cfg.line_height};
   // corner order: top-left, bottom-right, bottom-left, top-right
   assign right_side = k_ff[0];
   assign bottom     = k_ff[0] ^ k_ff[1];

   always_comb begin
      load      = 1'b0;
      pop       = 1'b0;
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      vcount_in = vcount_ff;
      if (head_valid) begin
         case (head_entry.kind)
            KIND_START: begin
               pop       = 1'b1;
               pen_x_in  = head_entry.x;
               pen_y_in  = head_entry.y;
               vcount_in = '0;
            end
            KIND_SPACE: begin
               pop      = 1'b1;
               pen_x_in = pen_x_ff + {8'd0, cfg.space_advance};
            end
            KIND_DRAW: begin
               load = out_free;
               if (out_free && k_ff == 2'd3) begin
                  pop       = 1'b1;
                  pen_x_in  = x1 + {8'd0, cfg.glyph_gap};
                  vcount_in = vcount_ff + 16'd4;
               end
            end
            default: pop = 1'b1;
         endcase
      end
   end

   assign k_in         = load ? k_ff + 1'b1 : k_ff;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         vcount_ff    <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         vcount_ff    <= vcount_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= vcount_ff + {14'd0, k_ff};
         pos_x_ff <= right_side ? x1 : pen_x_ff;
         pos_y_ff <= bottom ? y1 : pen_y_ff;
         tex_u_ff <= right_side ? head_entry.glyph.right : head_entry.glyph.left;
         tex_v_ff <= bottom;
         last_ff  <= k_ff == 2'd3;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_tex_u        = tex_u_ff;
   assign rsp_tex_v        = tex_v_ff;
   assign rsp_last         = last_ff;

   // a quad in flight keeps its draw entry at the head of the queue
   `GQVG_ASSERT_IMPL(a_quad_holds_head, k_ff != 2'd0,
      head_valid && head_entry.kind == KIND_DRAW, "quad in flight without draw entry")

   // the closing corner of a quad is top-right and ends a group of four
   `GQVG_ASSERT_IMPL(a_last_corner, rsp_valid_ff && last_ff,
      index_ff[1:0] == 2'd3 && !tex_v_ff, "last beat is not the fourth corner")

   `GQVG_ASSERT_NEXT(a_draw_advance, pop && head_entry.kind == KIND_DRAW,
      pen_x_ff == $past(x1 + {8'd0, cfg.glyph_gap}) && k_ff == 2'd0,
      "pen advance after quad is wrong")
endmodule
